// ----- src/multi_channel_soft_timer_unit_macros.svh -----
// assertion macros for the soft timer unit checker
// expects clk and arst_n in the scope of use
`ifndef MULTI_CHANNEL_SOFT_TIMER_UNIT_MACROS_SVH
`define MULTI_CHANNEL_SOFT_TIMER_UNIT_MACROS_SVH

// checked only out of reset
`define MCST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MCST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mcst_pkg.sv -----
// shared types and constants of the soft timer unit
// no dependencies
package mcst_pkg;

	localparam int unsigned MAX_TIMERS = 16;
	localparam logic [31:0] STOPPED_DUE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_TICK           = 3'd0,
		CMD_SET_PERIOD     = 3'd1,
		CMD_START_ONCE     = 3'd2,
		CMD_START_PERIODIC = 3'd3,
		CMD_STOP           = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  timer_index;
		logic [31:0] period_ms;
	} cmd_t;

	typedef struct packed {
		logic [15:0] fired_mask;
		logic        any_running;
		logic [31:0] nearest_due;
		logic [31:0] reload_value;
	} res_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic        apply;
		logic        tick;
		logic [2:0]  command;
		logic [31:0] now;
		logic [31:0] period;
	} cell_ctrl_t;

endpackage

// ----- src/mcst_cell.sv -----
// one timer cell: due time, period and repeat flag of one timer,
// plus one stage of the earliest-due chain; uses mcst_pkg
module mcst_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mcst_pkg::cell_ctrl_t ctrl,
	input  logic               sel,
	input  logic [31:0]        min_in,
	output logic [31:0]        min_out,
	output logic               fired
);
	import mcst_pkg::*;

	logic [31:0] due_q, period_q, min_q;
	logic        repeat_q, fired_q;
	logic [31:0] due_d, period_d;
	logic        repeat_d, fired_d;
	logic [31:0] eff_period, arm_due, next_due;
	logic [32:0] arm_sum, next_sum;
	logic        hit;

	// a zero period counts as one ms
	assign eff_period = (period_q == 32'd0) ? 32'd1 : period_q;

	assign arm_sum  = {1'b0, ctrl.now} + {1'b0, eff_period};
	assign arm_due  = (arm_sum >= {1'b0, STOPPED_DUE}) ? STOPPED_DUE : arm_sum[31:0];
	// an armed due time never lags now, so one period always catches up
	assign next_sum = {1'b0, due_q} + {1'b0, eff_period};
	assign next_due = (next_sum >= {1'b0, STOPPED_DUE}) ? STOPPED_DUE : next_sum[31:0];

	assign hit = (due_q != STOPPED_DUE) && (due_q <= ctrl.now);

	always_comb begin
		due_d    = due_q;
		period_d = period_q;
		repeat_d = repeat_q;
		fired_d  = fired_q;
		if (ctrl.apply) begin
			fired_d = 1'b0;
			if (ctrl.tick) begin
				fired_d = hit;
				if (hit) begin
					due_d = repeat_q ? next_due : STOPPED_DUE;
				end
			end else if (sel) begin
				case (ctrl.command)
					CMD_SET_PERIOD: begin
						period_d = ctrl.period;
					end
					CMD_START_ONCE: begin
						repeat_d = 1'b0;
						due_d    = arm_due;
					end
					CMD_START_PERIODIC: begin
						repeat_d = 1'b1;
						due_d    = arm_due;
					end
					CMD_STOP: begin
						repeat_d = 1'b0;
						due_d    = STOPPED_DUE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q    <= STOPPED_DUE;
			period_q <= 32'd0;
			repeat_q <= 1'b0;
			fired_q  <= 1'b0;
			min_q    <= STOPPED_DUE;
		end else begin
			due_q    <= due_d;
			period_q <= period_d;
			repeat_q <= repeat_d;
			fired_q  <= fired_d;
			min_q    <= (due_q < min_in) ? due_q : min_in;
		end
	end

	assign min_out = min_q;
	assign fired   = fired_q;

endmodule

// ----- src/multi_channel_soft_timer_unit.sv -----
// Bank of TIMER_COUNT millisecond timers driven by command words (tick, set period,
// start once, start periodic, stop). Each command yields one result word with the
// fired mask, the earliest due time and the reload value. A command passes through
// the sequencer states in order: an apply state in which every cell updates at once,
// a scan state while the earliest due time ripples through the chain of cells one
// cell per cycle, and a done state that loads the result register. A command word is
// taken only in the idle state, so a new command waits until the last one is through. The
// next command is taken while a result still waits in that register; a result still
// stalled when the next one is ready holds the sequencer until it is taken.
// Depends on mcst_pkg and mcst_cell.
module multi_channel_soft_timer_unit #(
	parameter int unsigned TIMER_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  mcst_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output mcst_pkg::res_t res
);
	import mcst_pkg::*;

	localparam int unsigned CW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(TIMER_COUNT - 1);

	state_e      state_q, state_d;
	cmd_t        cmd_s1;
	logic [31:0] now_q, now_new;
	logic [CW-1:0] cnt_q;
	res_t        res_q;
	logic        res_valid_q;
	logic        take, apply, load;
	logic        is_tick;
	cell_ctrl_t  ctrl;
	logic [31:0] min_chain [TIMER_COUNT+1];
	logic [MAX_TIMERS-1:0] fired_vec, sel_vec;
	logic [31:0] nearest, span;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == CNT_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || !res_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_stall = 1'b1;
		apply     = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE:  cmd_stall = 1'b0;
			ST_APPLY: apply = 1'b1;
			ST_DONE:  load = !res_valid_q || !res_stall;
			default: begin
			end
		endcase
	end

	assign take    = cmd_valid && !cmd_stall;
	assign is_tick = (cmd_s1.command == CMD_TICK);
	assign now_new = is_tick ? now_q + 32'd1 : now_q;

	always_comb begin
		ctrl.apply   = apply;
		ctrl.tick    = is_tick;
		ctrl.command = cmd_s1.command;
		ctrl.now     = now_new;
		ctrl.period  = cmd_s1.period_ms;
	end

	always_comb begin
		sel_vec = '0;
		sel_vec[cmd_s1.timer_index] = 1'b1;
	end

	assign min_chain[0] = STOPPED_DUE;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TIMERS; gi++) begin : g_cell
			if (gi < TIMER_COUNT) begin : g_on
				mcst_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctrl    (ctrl),
					.sel     (sel_vec[gi]),
					.min_in  (min_chain[gi]),
					.min_out (min_chain[gi+1]),
					.fired   (fired_vec[gi])
				);
			end else begin : g_off
				assign fired_vec[gi] = 1'b0;
			end
		end
	endgenerate

	assign nearest = min_chain[TIMER_COUNT];
	assign span    = nearest - now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= 32'd0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply) now_q <= now_new;
			if (apply) begin
				cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) cmd_s1 <= cmd;
		if (load) begin
			res_q.fired_mask   <= fired_vec;
			res_q.any_running  <= (nearest != STOPPED_DUE);
			res_q.nearest_due  <= nearest;
			res_q.reload_value <= (nearest != STOPPED_DUE) ? {span[30:0], 1'b0} - 32'd1
			                                              : 32'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- src/mcst_checker.sv -----
// port-level checks for the soft timer unit, bound to the top level
// depends on mcst_pkg and the macros header
`include "multi_channel_soft_timer_unit_macros.svh"

module mcst_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input mcst_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_stall,
	input mcst_pkg::res_t res
);
	import mcst_pkg::*;

	// a waiting result word holds
	`MCST_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result word changed while stalled")
	// one command at a time
	`MCST_ASSERT(a_busy_after_take, cmd_valid && !cmd_stall |=> cmd_stall, "command taken while busy")
	`MCST_ASSERT(a_running_flag, res_valid |-> (res.any_running == (res.nearest_due != STOPPED_DUE)), "running flag disagrees with nearest due")
	`MCST_ASSERT(a_reload_idle, res_valid && !res.any_running |-> (res.reload_value == 32'd0), "reload not zero with no timer armed")
	`MCST_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res_valid, "result valid during reset")

endmodule

bind multi_channel_soft_timer_unit mcst_checker u_mcst_checker (.*);

// ----- sim/mcst_timer_checker.sv -----
`timescale 1ns / 100ps
// result checker for the soft timer unit: keeps its own copy of the timer bank, predicts
// one result word per accepted command word and compares the result channel against it
// depends on mcst_pkg
module mcst_timer_checker #(
	parameter int unsigned TIMER_COUNT = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_stall,
	input  mcst_pkg::cmd_t cmd,
	input  logic           res_valid,
	input  logic           res_stall,
	input  mcst_pkg::res_t res,
	output int             mismatches,
	output int             pending,
	output int             fires
);
	import mcst_pkg::*;

	logic [31:0] now_ms;
	logic [31:0] due_at [MAX_TIMERS];
	logic [31:0] period_q [MAX_TIMERS];
	logic        repeating [MAX_TIMERS];
	res_t        awaited_words [$];

	// a stored period of zero runs as one millisecond
	function automatic logic [31:0] live_period(int unsigned i);
		return (period_q[i] == '0) ? 32'd1 : period_q[i];
	endfunction

	function automatic logic [31:0] clamp_due(logic [63:0] d);
		return (d >= {32'd0, STOPPED_DUE}) ? STOPPED_DUE : d[31:0];
	endfunction

	function automatic res_t step_timer_bank(cmd_t w);
		res_t        r;
		cmd_e        op;
		logic [63:0] step;
		logic [63:0] nxt;
		logic [63:0] lag;
		logic [31:0] low;
		logic [31:0] span;
		int unsigned i;
		r = '0;
		op = cmd_e'(w.command);
		if (op == CMD_TICK) begin
			now_ms = now_ms + 32'd1;
			for (i = 0; i < TIMER_COUNT; i++) begin
				if (due_at[i] != STOPPED_DUE && due_at[i] <= now_ms) begin
					r.fired_mask[i] = 1'b1;
					if (repeating[i]) begin
						step = {32'd0, live_period(i)};
						nxt = {32'd0, due_at[i]} + step;
						// catch up by whole periods if the timer fell behind
						if (nxt < {32'd0, now_ms}) begin
							lag = {32'd0, now_ms} - nxt + step - 64'd1;
							nxt = nxt + (lag / step) * step;
						end
						due_at[i] = clamp_due(nxt);
					end else begin
						due_at[i] = STOPPED_DUE;
					end
				end
			end
		end else if (w.timer_index < TIMER_COUNT) begin
			case (op)
				CMD_SET_PERIOD: begin
					period_q[w.timer_index] = w.period_ms;
				end
				CMD_START_ONCE, CMD_START_PERIODIC: begin
					repeating[w.timer_index] = (op == CMD_START_PERIODIC);
					due_at[w.timer_index] =
						clamp_due({32'd0, now_ms} + live_period(w.timer_index));
				end
				CMD_STOP: begin
					due_at[w.timer_index] = STOPPED_DUE;
					repeating[w.timer_index] = 1'b0;
				end
				default: ;
			endcase
		end
		low = STOPPED_DUE;
		for (i = 0; i < MAX_TIMERS; i++) begin
			if (due_at[i] < low)
				low = due_at[i];
		end
		r.any_running = (low != STOPPED_DUE);
		r.nearest_due = low;
		if (low != STOPPED_DUE) begin
			span = low - now_ms;
			r.reload_value = (span << 1) - 32'd1;
		end
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < 50)
			$display("%0t ns: %s wrong, got %h, wanted %h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			now_ms = '0;
			for (int i = 0; i < MAX_TIMERS; i++) begin
				due_at[i] = STOPPED_DUE;
				period_q[i] = '0;
				repeating[i] = 1'b0;
			end
			awaited_words.delete();
			mismatches = 0;
			fires = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited_words.size() == 0) begin
					report("result word with nothing awaited", res.nearest_due, STOPPED_DUE);
				end else begin
					want = awaited_words.pop_front();
					fires += $countones(want.fired_mask);
					if (res.fired_mask !== want.fired_mask)
						report("fired_mask", 32'(res.fired_mask), 32'(want.fired_mask));
					if (res.any_running !== want.any_running)
						report("any_running", 32'(res.any_running), 32'(want.any_running));
					if (res.nearest_due !== want.nearest_due)
						report("nearest_due", res.nearest_due, want.nearest_due);
					if (res.reload_value !== want.reload_value)
						report("reload_value", res.reload_value, want.reload_value);
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_words.push_back(step_timer_bank(cmd));
		end
		pending = awaited_words.size();
	end

endmodule

// ----- sim/tb_multi_channel_soft_timer_unit.sv -----
`timescale 1ns / 100ps
// top of the soft timer unit testbench: clock, reset, command words and result stalls
// depends on mcst_pkg, multi_channel_soft_timer_unit and mcst_timer_checker
module tb_multi_channel_soft_timer_unit;
	import mcst_pkg::*;

	localparam int unsigned TIMER_COUNT  = MAX_TIMERS;
	localparam int unsigned RANDOM_WORDS = 1050;
	localparam int unsigned CYCLE_LIMIT  = 900_000;
	localparam int unsigned DRAIN_CYCLES = TIMER_COUNT + 24;
	localparam logic [2:0]  CMD_RSVD_FIRST = 3'd5;
	localparam logic [2:0]  CMD_RSVD_LAST  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	int          mismatches;
	int          pending;
	int          fires;
	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	bit          calm = 1'b0;

	multi_channel_soft_timer_unit #(
		.TIMER_COUNT(TIMER_COUNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	mcst_timer_checker #(
		.TIMER_COUNT(TIMER_COUNT)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.mismatches(mismatches),
		.pending   (pending),
		.fires     (fires)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d words still awaited", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned draw_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cmd_t make_word(cmd_e op, logic [3:0] idx, logic [31:0] per);
		cmd_t w;
		w.command = op;
		w.timer_index = idx;
		w.period_ms = per;
		return w;
	endfunction

	function automatic cmd_t random_word();
		cmd_t        w;
		int unsigned pick;
		int unsigned sel;
		w = make_word(CMD_TICK, 4'($urandom_range(0, 15)), $urandom());
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 19);
		if (pick < 50) begin
			w.command = CMD_TICK;
		end else if (pick < 62) begin
			w.command = CMD_SET_PERIOD;
			// short periods keep timers firing, one pick is zero and the rest probe the wide end
			if (sel == 0)
				w.period_ms = '0;
			else if (sel == 1)
				w.period_ms = STOPPED_DUE - 32'($urandom_range(0, 3));
			else if (sel > 3)
				w.period_ms = 32'($urandom_range(1, 12));
		end else if (pick < 74) begin
			w.command = CMD_START_PERIODIC;
		end else if (pick < 84) begin
			w.command = CMD_START_ONCE;
		end else if (pick < 96) begin
			w.command = CMD_STOP;
		end else begin
			w.command = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		end
		return w;
	endfunction

	task automatic issue_command(cmd_t w);
		int unsigned gap;
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_sent++;
		gap = calm ? 0 : draw_gap();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			cmd <= {7'($urandom()), $urandom()};
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned hold;
		@(posedge clk);
		forever begin
			hold = calm ? 0 : draw_gap();
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		cmd_t        directed [$];
		cmd_t        w;
		logic [3:0]  idx;
		int unsigned i;

		// falling edge at time zero so the design resets at once
		arst_n <= 1'b0;

		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		// zero period behaves as one millisecond
		directed.push_back(make_word(CMD_SET_PERIOD, 4'd0, '0));
		directed.push_back(make_word(CMD_START_ONCE, 4'd0, '1));
		directed.push_back(make_word(CMD_TICK, 4'd9, '1));
		// due time past 32 bits saturates and leaves the timer stopped
		directed.push_back(make_word(CMD_SET_PERIOD, 4'd15, '1));
		directed.push_back(make_word(CMD_START_PERIODIC, 4'd15, '0));
		// far due time, reload wraps
		directed.push_back(make_word(CMD_SET_PERIOD, 4'd13, 32'h8000_0000));
		directed.push_back(make_word(CMD_START_ONCE, 4'd13, '0));
		directed.push_back(make_word(CMD_SET_PERIOD, 4'd1, 32'd3));
		directed.push_back(make_word(CMD_START_PERIODIC, 4'd1, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		// restart while armed
		directed.push_back(make_word(CMD_START_ONCE, 4'd1, '0));
		directed.push_back(make_word(CMD_STOP, 4'd13, '0));
		directed.push_back(make_word(CMD_STOP, 4'd1, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		w = make_word(CMD_TICK, 4'd15, '1);
		w.command = CMD_RSVD_FIRST;
		directed.push_back(w);
		w = make_word(CMD_TICK, 4'd0, '0);
		w.command = CMD_RSVD_LAST;
		directed.push_back(w);
		directed.push_back(make_word(CMD_SET_PERIOD, 4'd2, 32'd2));
		directed.push_back(make_word(CMD_START_PERIODIC, 4'd2, '0));
		directed.push_back(make_word(CMD_START_PERIODIC, 4'd0, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		directed.push_back(make_word(CMD_TICK, 4'd0, '0));
		directed.push_back(make_word(CMD_STOP, 4'd7, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			issue_command(directed[k]);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				// program a short period and arm the same timer straight away
				idx = 4'($urandom_range(0, 15));
				issue_command(make_word(CMD_SET_PERIOD, idx, 32'($urandom_range(0, 6))));
				issue_command(make_word($urandom_range(0, 1) ? CMD_START_PERIODIC
					: CMD_START_ONCE, idx, $urandom()));
			end else begin
				issue_command(random_word());
			end
		end
		cmd_valid <= 1'b0;

		do
			@(negedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d command words driven in %0d cycles", words_sent, cycles);
		$display("%0d timer expiries predicted and compared", fires);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
